### rtl/core/wp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wp_pkg: shared types, constants and functions of the whirlpool hash engine
// ----------------------------------------------------------------------------
package wp_pkg;

    localparam int WP_ROUNDS = 10;
    localparam int WP_QDEPTH = 2;
    localparam logic [63:0] WP_PAD_WORD = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        final_flag;
    } t_out_item;

    typedef logic [7:0][63:0] t_block;

    // classified job handed from front to back
    typedef struct packed {
        logic [63:0] word;     // word to store, already padded when last
        logic        last;
        logic        full;     // last word carries all eight bytes, pad goes in the next word
        logic [63:0] bits;     // total message length in bits, valid when last
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD2,
        ST_EMIT
    } t_back_state;

    function automatic logic [3:0] box_e(input logic [3:0] x);
        logic [3:0] r;
        case (x)
            4'h0: r = 4'h1; 4'h1: r = 4'hB; 4'h2: r = 4'h9; 4'h3: r = 4'hC;
            4'h4: r = 4'hD; 4'h5: r = 4'h6; 4'h6: r = 4'hF; 4'h7: r = 4'h3;
            4'h8: r = 4'hE; 4'h9: r = 4'h8; 4'hA: r = 4'h7; 4'hB: r = 4'h4;
            4'hC: r = 4'hA; 4'hD: r = 4'h2; 4'hE: r = 4'h5; default: r = 4'h0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] box_ei(input logic [3:0] x);
        logic [3:0] r;
        case (x)
            4'h0: r = 4'hF; 4'h1: r = 4'h0; 4'h2: r = 4'hD; 4'h3: r = 4'h7;
            4'h4: r = 4'hB; 4'h5: r = 4'hE; 4'h6: r = 4'h5; 4'h7: r = 4'hA;
            4'h8: r = 4'h9; 4'h9: r = 4'h2; 4'hA: r = 4'hC; 4'hB: r = 4'h1;
            4'hC: r = 4'h3; 4'hD: r = 4'h4; 4'hE: r = 4'h8; default: r = 4'h6;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] box_r(input logic [3:0] x);
        logic [3:0] r;
        case (x)
            4'h0: r = 4'h7; 4'h1: r = 4'hC; 4'h2: r = 4'hB; 4'h3: r = 4'hD;
            4'h4: r = 4'hE; 4'h5: r = 4'h4; 4'h6: r = 4'h9; 4'h7: r = 4'hF;
            4'h8: r = 4'h6; 4'h9: r = 4'h3; 4'hA: r = 4'h8; 4'hB: r = 4'hA;
            4'hC: r = 4'h2; 4'hD: r = 4'h5; 4'hE: r = 4'h1; default: r = 4'h0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [3:0] y1, y2, m;
        y1 = box_e(x[7:4]);
        y2 = box_ei(x[3:0]);
        m  = box_r(y1 ^ y2);
        return {box_e(y1 ^ m), box_ei(y2 ^ m)};
    endfunction

    // multiply by 2 in GF(2^8) modulo 0x11d
    function automatic logic [7:0] x2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1D : 8'h00);
    endfunction

    // sbox then mds row {1,1,4,1,8,5,2,9}, rotated right by k bytes
    function automatic logic [63:0] mix_entry(input logic [2:0] k, input logic [7:0] x);
        logic [7:0]  s, s2, s4, s8;
        logic [63:0] w;
        s  = sbox(x);
        s2 = x2(s);
        s4 = x2(s2);
        s8 = x2(s4);
        w  = {s, s, s4, s, s8, s4 ^ s, s2, s8 ^ s};
        return (w >> {k, 3'b000}) | (w << (7'd64 - {1'b0, k, 3'b000}));
    endfunction

    function automatic t_block round_layer(input t_block src, input t_block add);
        t_block d;
        for (int i = 0; i < 8; i++) begin
            d[i] = add[i];
            for (int k = 0; k < 8; k++) begin
                d[i] ^= mix_entry(3'(k), src[(i - k) & 7][63 - 8 * k -: 8]);
            end
        end
        return d;
    endfunction

    function automatic logic [63:0] round_const(input logic [3:0] r);
        logic [63:0] c;
        for (int k = 0; k < 8; k++) begin
            c[63 - 8 * k -: 8] = sbox(8'({r - 4'd1, 3'b000}) + 8'(k));
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/core/wp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wp_front: input classifier
// masks and pads the last word, tracks message length, pushes jobs to a queue
// ----------------------------------------------------------------------------
module wp_front
    import wp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_in_item i_item,
    output logic          o_push,
    output t_job          o_job
);
    logic [63:0] r_bits, n_bits;
    logic [3:0]  n_cnt;
    logic [63:0] pad, mask;

    always_comb begin
        n_cnt = (!i_item.last_word || i_item.byte_count > 4'd8) ? 4'd8 : i_item.byte_count;
        mask  = (n_cnt == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> {n_cnt, 3'b000});
        pad   = (n_cnt == 4'd8) ? 64'd0 : (64'h80 << (7'd56 - {n_cnt[2:0], 3'b000}));
        n_bits = r_bits + {57'd0, n_cnt, 3'b000};
        o_push = i_start;
        o_job.word = (i_item.data_word & mask) | pad;
        o_job.last = i_item.last_word;
        o_job.full = i_item.last_word && (n_cnt == 4'd8);
        o_job.bits = n_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else if (i_start) begin
            r_bits <= i_item.last_word ? 64'd0 : n_bits;
        end
    end
endmodule
`default_nettype wire

### rtl/core/wp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wp_back: compression unit
// one cipher round plus key schedule per cycle, padding and digest output
// ----------------------------------------------------------------------------
module wp_back
    import wp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_job  i_job,
    output logic       o_pop,
    output logic       o_busy,
    output logic       o_strobe,
    output t_out_item  o_result
);
    t_back_state r_st, n_st;
    t_block      r_chain, r_buf, r_key, r_state;
    logic [2:0]  r_pos, r_idx;
    logic [3:0]  r_rnd;
    logic        r_fin;       // compression leads to digest output
    logic        r_two;       // a second block, holding the length, follows
    logic        r_lead;      // second block starts with the pad word
    logic [63:0] r_bits;
    t_block      nk, ns, lenblk;
    logic        start_c;
    t_block      blk;
    logic [3:0]  pad_pos;

    always_comb begin
        nk = round_layer(r_key, '0);
        nk[0] ^= round_const(r_rnd);
        ns = round_layer(r_state, nk);
        // word index of the pad byte, 8 when it spills into a new block
        pad_pos = {1'b0, r_pos} + {3'b000, i_job.full};
        // block for a new job (word at r_pos), with zero fill when last
        blk = r_buf;
        blk[r_pos] = i_job.word;
        if (i_job.last) begin
            for (int i = 0; i < 8; i++) begin
                if (3'(i) > r_pos) blk[i] = '0;
            end
            if (i_job.full && r_pos != 3'd7) blk[r_pos + 3'd1] = WP_PAD_WORD;
            if (pad_pos < 4'd4) blk[7] = i_job.bits;
        end
        lenblk = '0;
        lenblk[0] = r_lead ? WP_PAD_WORD : 64'd0;
        lenblk[7] = r_bits;
    end

    always_comb begin
        n_st = r_st;
        o_pop = 1'b0;
        start_c = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    if (i_job.last || r_pos == 3'd7) begin
                        start_c = 1'b1;
                        n_st = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                if (r_rnd == 4'(WP_ROUNDS)) n_st = r_two ? ST_PAD2 : (r_fin ? ST_EMIT : ST_IDLE);
            end
            ST_PAD2:  n_st = ST_ROUND;
            ST_EMIT:  if (r_idx == 3'd7) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
        o_busy = 1'b0;
        o_strobe = (r_st == ST_EMIT);
        o_result.digest_word = r_chain[r_idx];
        o_result.word_index  = r_idx;
        o_result.final_flag  = (r_idx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_chain <= '0;
            r_pos <= '0;
            r_idx <= '0;
            r_rnd <= '0;
            r_fin <= 1'b0;
            r_two <= 1'b0;
            r_lead <= 1'b0;
        end else begin
            r_st <= n_st;
            case (r_st)
                ST_IDLE: begin
                    if (o_pop) begin
                        if (start_c) begin
                            r_buf   <= blk;
                            r_key   <= r_chain;
                            r_state <= blk ^ r_chain;
                            r_rnd   <= 4'd1;
                            r_fin   <= i_job.last;
                            r_two   <= i_job.last && pad_pos >= 4'd4;
                            r_lead  <= i_job.full && r_pos == 3'd7;
                            r_bits  <= i_job.bits;
                            r_pos   <= '0;
                        end else begin
                            r_buf[r_pos] <= i_job.word;
                            r_pos <= r_pos + 3'd1;
                        end
                    end
                end
                ST_ROUND: begin
                    r_key <= nk;
                    r_state <= ns;
                    if (r_rnd == 4'(WP_ROUNDS)) begin
                        r_rnd <= '0;
                        for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] ^ ns[i] ^ r_buf[i];
                    end else begin
                        r_rnd <= r_rnd + 4'd1;
                    end
                end
                ST_PAD2: begin
                    r_two <= 1'b0;
                    r_buf <= lenblk;
                    r_key <= r_chain;
                    r_state <= lenblk ^ r_chain;
                    r_rnd <= 4'd1;
                end
                ST_EMIT: begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd7) r_chain <= '0;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> r_rnd == 4'd0)
        else $error("digest output during compression");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_IDLE) |-> r_rnd == 4'd0)
        else $error("round counter not cleared when idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_EMIT && r_idx == 3'd7) |=> r_chain == '0 && r_pos == 3'd0)
        else $error("state not cleared after digest");
endmodule
`default_nettype wire

### rtl/core/wp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wp_queue: job queue
// small fifo between the classifier and the compression unit
// ----------------------------------------------------------------------------
module wp_queue
    import wp_pkg::*;
#(
    parameter int DEPTH = WP_QDEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_valid,
    output logic      o_full,
    output t_job      o_job
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_job             r_mem [DEPTH];
    logic [AW-1:0]    r_rd, r_wr;
    logic [AW:0]      r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (AW + 1)'(DEPTH));
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (AW + 1)'(i_push) - (AW + 1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

### rtl/core/whirlpool_hash_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// whirlpool_hash_engine: streaming Whirlpool-512 hash
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy is high while
// the two-entry job queue is full. Words are queued and absorbed one a cycle
// while no compression or digest output runs; every eighth word, and the last
// one, starts a compression, one round plus key schedule per cycle in a single
// round unit. A last word whose pad or length does not fit in the current
// block needs a second compression. The 8 digest words then leave on
// consecutive cycles with o_strobe high, and the receiver cannot stall them.
module whirlpool_hash_engine
    import wp_pkg::*;
#(
    parameter int QDEPTH = WP_QDEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire t_in_item  i_item,
    output logic           busy,
    output logic           o_strobe,
    output t_out_item      o_result
);
    logic  push, pop, qvalid, qfull, bbusy;
    t_job  fjob, qjob;

    assign busy = qfull;

    wp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start && !busy),
        .i_item(i_item), .o_push(push), .o_job(fjob)
    );

    wp_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(fjob),
        .i_pop(pop), .o_valid(qvalid), .o_full(qfull), .o_job(qjob)
    );

    wp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(qvalid), .i_job(qjob),
        .o_pop(pop), .o_busy(bbusy), .o_strobe(o_strobe), .o_result(o_result)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n) bbusy == 1'b0)
        else $error("back busy unexpectedly");
endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whirlpool hash engine testbench
// ----------------------------------------------------------------------------
// Feeds messages as command-style transactions, predicts each digest with an
// independent Whirlpool model and checks every strobed digest word in order.
// A directed table covers empty, partial, full, long-pad and oversized-count
// cases; random messages of mixed length and random start gaps follow.
// ----------------------------------------------------------------------------
module testbench;
    import wp_pkg::t_in_item;
    import wp_pkg::t_out_item;

    localparam int NUM_RANDOM_MSGS = 70;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    whirlpool_hash_engine dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // predictor state
    logic [63:0] hash_chain [8];
    logic [63:0] msg_block [8];
    int unsigned blk_fill;
    logic [63:0] msg_bits;
    t_out_item   digest_fifo [$];
    int          error_count;
    int          word_count;
    int          digest_count;

    // directed table: data, count, last
    t_in_item dir_items [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1D : 8'h00);
    endfunction

    function automatic logic [7:0] wp_sub(input logic [7:0] x);
        logic [3:0] e_tab [16];
        logic [3:0] ei_tab [16];
        logic [3:0] r_tab [16];
        logic [3:0] a, b, m;
        e_tab  = '{4'h1, 4'hB, 4'h9, 4'hC, 4'hD, 4'h6, 4'hF, 4'h3,
                   4'hE, 4'h8, 4'h7, 4'h4, 4'hA, 4'h2, 4'h5, 4'h0};
        ei_tab = '{4'hF, 4'h0, 4'hD, 4'h7, 4'hB, 4'hE, 4'h5, 4'hA,
                   4'h9, 4'h2, 4'hC, 4'h1, 4'h3, 4'h4, 4'h8, 4'h6};
        r_tab  = '{4'h7, 4'hC, 4'hB, 4'hD, 4'hE, 4'h4, 4'h9, 4'hF,
                   4'h6, 4'h3, 4'h8, 4'hA, 4'h2, 4'h5, 4'h1, 4'h0};
        a = e_tab[x[7:4]];
        b = ei_tab[x[3:0]];
        m = r_tab[a ^ b];
        return {e_tab[a ^ m], ei_tab[b ^ m]};
    endfunction

    // one column of the diffusion layer, rotated right by pos bytes
    function automatic logic [63:0] col_word(input int pos, input logic [7:0] x);
        logic [7:0]  s1, s2, s4, s8;
        logic [63:0] w;
        s1 = wp_sub(x);
        s2 = gf_dbl(s1);
        s4 = gf_dbl(s2);
        s8 = gf_dbl(s4);
        w = {s1, s1, s4, s1, s8, s4 ^ s1, s2, s8 ^ s1};
        if (pos != 0) w = (w >> (8 * pos)) | (w << (64 - 8 * pos));
        return w;
    endfunction

    task automatic wp_round(input logic [63:0] src [8], output logic [63:0] dst [8]);
        for (int i = 0; i < 8; i++) begin
            dst[i] = '0;
            for (int k = 0; k < 8; k++)
                dst[i] ^= col_word(k, src[(i - k) & 7][63 - 8 * k -: 8]);
        end
    endtask

    task automatic compress_block();
        logic [63:0] key [8];
        logic [63:0] st [8];
        logic [63:0] nxt [8];
        for (int i = 0; i < 8; i++) begin
            key[i] = hash_chain[i];
            st[i]  = msg_block[i] ^ key[i];
        end
        for (int r = 1; r <= 10; r++) begin
            wp_round(key, nxt);
            for (int k = 0; k < 8; k++)
                nxt[0][63 - 8 * k -: 8] ^= wp_sub(8'(8 * (r - 1) + k));
            key = nxt;
            wp_round(st, nxt);
            for (int i = 0; i < 8; i++) st[i] = nxt[i] ^ key[i];
        end
        for (int i = 0; i < 8; i++) hash_chain[i] ^= st[i] ^ msg_block[i];
    endtask

    task automatic absorb(input logic [63:0] w);
        msg_block[blk_fill] = w;
        blk_fill = (blk_fill + 1) % 8;
        if (blk_fill == 0) compress_block();
    endtask

    task automatic predict_word(input t_in_item it);
        int unsigned n;
        logic [63:0] padded;
        t_out_item   r;
        if (!it.last_word) begin
            msg_bits += 64;
            absorb(it.data_word);
            return;
        end
        n = (it.byte_count > 8) ? 8 : it.byte_count;
        if (n == 8) begin
            msg_bits += 64;
            absorb(it.data_word);
            padded = 64'h80 << 56;
        end else begin
            padded = (n == 0) ? 64'd0 : (it.data_word & ~((64'd1 << (64 - 8 * n)) - 64'd1));
            msg_bits += 64'(8 * n);
            padded |= 64'h80 << (56 - 8 * n);
        end
        msg_block[blk_fill] = padded;
        if (blk_fill >= 4) begin
            for (int i = blk_fill + 1; i < 8; i++) msg_block[i] = '0;
            compress_block();
            for (int i = 0; i < 7; i++) msg_block[i] = '0;
        end else begin
            for (int i = blk_fill + 1; i < 7; i++) msg_block[i] = '0;
        end
        msg_block[7] = msg_bits;
        compress_block();
        for (int i = 0; i < 8; i++) begin
            r.digest_word = hash_chain[i];
            r.word_index  = 3'(i);
            r.final_flag  = (i == 7);
            digest_fifo.push_back(r);
            hash_chain[i] = '0;
        end
        blk_fill = 0;
        msg_bits = '0;
    endtask

    // digest checker
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_strobe) begin
            digest_count++;
            if (digest_fifo.size() == 0) begin
                $display("%0t: unexpected digest word %h idx %0d", $time,
                         o_result.digest_word, o_result.word_index);
                error_count++;
            end else begin
                exp_r = digest_fifo.pop_front();
                if (exp_r !== o_result) begin
                    $display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b",
                             $time, exp_r.digest_word, exp_r.word_index,
                             exp_r.final_flag, o_result.digest_word,
                             o_result.word_index, o_result.final_flag);
                    error_count++;
                end
            end
        end
    end

    // start stays high between back-to-back words and drops only for a gap
    task automatic send_word(input t_in_item it);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_word(it);
        word_count++;
        @(negedge i_clk);
    endtask

    // drop start and wait until every predicted digest word has been checked
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (digest_fifo.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_in_item mk(input logic [63:0] d, input logic [3:0] c,
                                     input logic l);
        t_in_item it;
        it.data_word = d; it.byte_count = c; it.last_word = l;
        return it;
    endfunction

    task automatic send_msg(input int words, input logic [3:0] tail_cnt);
        for (int i = 0; i < words - 1; i++)
            send_word(mk({$urandom, $urandom}, 4'($urandom), 1'b0));
        send_word(mk({$urandom, $urandom}, tail_cnt, 1'b1));
    endtask

    initial begin
        int len;
        hash_chain = '{default: '0};
        msg_block  = '{default: '0};
        blk_fill = 0; msg_bits = '0;
        error_count = 0; word_count = 0; digest_count = 0;
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty message, extremes, partial tails, long padding, count overflow
        dir_items.push_back(mk(64'h0, 4'd0, 1'b1));
        dir_items.push_back(mk('1, 4'd8, 1'b1));
        dir_items.push_back(mk('1, 4'd1, 1'b1));
        dir_items.push_back(mk(64'h0123456789ABCDEF, 4'd7, 1'b1));
        dir_items.push_back(mk('1, 4'd15, 1'b1));
        for (int i = 0; i < 4; i++) dir_items.push_back(mk('1, 4'd0, 1'b0));
        dir_items.push_back(mk(64'hAAAA_5555_AAAA_5555, 4'd3, 1'b1));
        for (int i = 0; i < 7; i++) dir_items.push_back(mk(64'h0, 4'd15, 1'b0));
        dir_items.push_back(mk(64'h5555_AAAA_5555_AAAA, 4'd9, 1'b1));
        foreach (dir_items[i]) send_word(dir_items[i]);

        // hold off until the directed digests are all out
        drain();

        for (int m = 0; m < NUM_RANDOM_MSGS; m++) begin
            case ($urandom_range(0, 3))
                0:       len = $urandom_range(1, 3);
                1:       len = $urandom_range(4, 8);
                2:       len = $urandom_range(9, 17);
                default: len = $urandom_range(1, 12);
            endcase
            send_msg(len, 4'($urandom_range(0, 15)));
            if (m == NUM_RANDOM_MSGS / 2)
                drain();
        end

        drain();
        repeat (50) @(negedge i_clk);
        $display("sent %0d words, checked %0d digest words over directed and random messages",
                 word_count, digest_count);
        if (error_count == 0 && digest_fifo.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout waiting for digest words");
        $display("*** FAILED ***");
        $finish;
    end
endmodule

### sim.f
rtl/core/wp_pkg.sv
rtl/core/wp_front.sv
rtl/core/wp_back.sv
rtl/core/wp_queue.sv
rtl/core/whirlpool_hash_engine.sv
dv/testbench.sv
